FILE: rtl/core/twmsp_pkg.sv
// ----------------------------------------------------------------------------
// twmsp_pkg
// Types, constants and helper functions for the three-wire motion sensor
// poller: sequence steps, bit phases, sensor register addresses and the setup
// table written during start-up.
// ----------------------------------------------------------------------------
package twmsp_pkg;

	// Build-time defaults.
	localparam int GAP_TICKS_DEFAULT = 16;
	localparam int MAX_TRIES_DEFAULT = 4;

	// Configuration port.
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IDX_DEAD_ZONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDX_LIMIT_X     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDX_LIMIT_Y     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDX_EXPECTED_ID = 2'd3;

	localparam logic [6:0]  DEAD_ZONE_RESET   = 7'd3;
	localparam logic [11:0] LIMIT_X_RESET     = 12'd480;
	localparam logic [11:0] LIMIT_Y_RESET     = 12'd272;
	localparam logic [7:0]  EXPECTED_ID_RESET = 8'h30;

	localparam logic [11:0] POS_X_RESET = 12'd240;
	localparam logic [11:0] POS_Y_RESET = 12'd136;

	// Sequence steps.
	typedef logic [3:0] step_t;
	localparam step_t STEP_ID          = 4'd0;
	localparam step_t STEP_REG1        = 4'd1;
	localparam step_t STEP_SETUP_FIRST = 4'd2;
	localparam step_t STEP_SETUP_LAST  = 4'd8;
	localparam step_t STEP_READY       = 4'd9;
	localparam step_t STEP_STATUS      = 4'd10;
	localparam step_t STEP_DX          = 4'd11;
	localparam step_t STEP_DY          = 4'd12;
	localparam step_t STEP_FAILED      = 4'd13;

	// Sensor register addresses.
	localparam logic [7:0] SNS_ID     = 8'h00;
	localparam logic [7:0] SNS_REG1   = 8'h01;
	localparam logic [7:0] SNS_STATUS = 8'h02;
	localparam logic [7:0] SNS_DX     = 8'h03;
	localparam logic [7:0] SNS_DY     = 8'h04;
	localparam int         STATUS_MOTION_BIT = 7;

	localparam int SETUP_LEN = 7;
	localparam logic [15:0] SETUP_SEQ [SETUP_LEN] = '{
		16'h85A0, 16'h8604, 16'h895A, 16'hDB9A, 16'hD109, 16'hD348, 16'h8900
	};

	// Bit phases of one transfer.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_GAP     = 3'd1,
		PH_TX_LOW  = 3'd2,
		PH_TX_HIGH = 3'd3,
		PH_TURN    = 3'd4,
		PH_RX_LOW  = 3'd5,
		PH_RX_HIGH = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] word;
	} xfer_t;

	localparam logic [1:0] FLAG_READY  = 2'b01;
	localparam logic [1:0] FLAG_FAILED = 2'b10;

	localparam int BITS_ADDR = 8;
	localparam int BITS_WORD = 16;

	// Division of a magnitude up to 128 by three: floor(m * 171 / 512).
	localparam logic [15:0] DIV3_MUL   = 16'd171;
	localparam int          DIV3_SHIFT = 9;

	typedef struct packed {
		logic        clock_pin;
		logic        data_pin;
		logic        data_drive;
		logic [11:0] cursor_x;
		logic [11:0] cursor_y;
		logic        ready_res;
		logic        init_failed;
		logic        busy_res;
	} result_t;

	// Transfer kind and the 16-bit word sent for a sequence step.
	function automatic xfer_t step_xfer(step_t s);
		xfer_t x;
		logic [2:0] idx;
		x.kind = KIND_NONE;
		x.word = '0;
		idx    = 3'(s - STEP_SETUP_FIRST);
		if (s == STEP_ID) begin
			x.kind = KIND_READ;
			x.word = {SNS_ID, 8'h00};
		end else if (s == STEP_REG1) begin
			x.kind = KIND_READ;
			x.word = {SNS_REG1, 8'h00};
		end else if (s inside {[STEP_SETUP_FIRST:STEP_SETUP_LAST]}) begin
			x.kind = KIND_WRITE;
			x.word = SETUP_SEQ[idx];
		end else if (s == STEP_STATUS) begin
			x.kind = KIND_READ;
			x.word = {SNS_STATUS, 8'h00};
		end else if (s == STEP_DX) begin
			x.kind = KIND_READ;
			x.word = {SNS_DX, 8'h00};
		end else if (s == STEP_DY) begin
			x.kind = KIND_READ;
			x.word = {SNS_DY, 8'h00};
		end
		return x;
	endfunction

	// Motion byte to cursor step: value / 3 toward zero, zero inside the dead zone.
	function automatic logic signed [6:0] motion_delta(logic [7:0] raw, logic [6:0] dz);
		logic [7:0]  mag;
		logic [15:0] prod;
		logic [6:0]  q;
		mag  = raw[7] ? 8'(~raw + 8'd1) : raw;
		prod = 16'(mag) * DIV3_MUL;
		q    = {1'b0, prod[DIV3_SHIFT+5:DIV3_SHIFT]};
		if (mag <= {1'b0, dz})
			return 7'sd0;
		return raw[7] ? $signed(7'(~q + 7'd1)) : $signed(q);
	endfunction

	function automatic logic [11:0] clamp_pos(logic signed [13:0] v, logic [11:0] lim);
		if (v < 14'sd0)
			return 12'd0;
		if (v > $signed({2'b00, lim}))
			return lim;
		return v[11:0];
	endfunction

endpackage

FILE: rtl/core/twmsp_if.sv
// ----------------------------------------------------------------------------
// twmsp_tick_if / twmsp_report_if
// Valid/ready channels of the poller: one carries the per-tick line sample
// and poll request, the other the pin levels, cursor and status.
// ----------------------------------------------------------------------------
interface twmsp_tick_if;
	logic valid;
	logic ready;
	logic sda_sample;
	logic poll_request;

	modport source (output valid, output sda_sample, output poll_request, input ready);
	modport sink (input valid, input sda_sample, input poll_request, output ready);
endinterface

interface twmsp_report_if;
	logic        valid;
	logic        ready;
	logic        clock_pin;
	logic        data_pin;
	logic        data_drive;
	logic [11:0] cursor_x;
	logic [11:0] cursor_y;
	logic        ready_res;
	logic        init_failed;
	logic        busy_res;

	modport source (
		output valid, output clock_pin, output data_pin, output data_drive,
		output cursor_x, output cursor_y, output ready_res, output init_failed,
		output busy_res, input ready
	);
	modport sink (
		input valid, input clock_pin, input data_pin, input data_drive,
		input cursor_x, input cursor_y, input ready_res, input init_failed,
		input busy_res, output ready
	);
endinterface

FILE: rtl/core/three_wire_motion_sensor_poller.sv
// A tick's report is registered, in the skid word if the output word is stalled.
// Throughput: one tick per cycle; a two-word output buffer keeps ticks flowing
// while a report waits, so the tick channel stalls only when both words are full.
// Reset (arst_n low, asynchronous): start-up restarts at the identity read,
// the cursor returns to (240, 136), flags clear and registers take their defaults.
// ----------------------------------------------------------------------------
// three_wire_motion_sensor_poller
// Three-wire half-duplex master for an optical motion sensor. Each tick is
// one half bit of the serial link; start-up, polling and cursor tracking run
// off a step register and a bit-phase state machine.
// ----------------------------------------------------------------------------
module three_wire_motion_sensor_poller
	import twmsp_pkg::*;
#(
	parameter int GAP_TICKS = GAP_TICKS_DEFAULT,
	parameter int MAX_TRIES = MAX_TRIES_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	twmsp_tick_if.sink            tick,
	twmsp_report_if.source        report,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int GapW = $clog2(GAP_TICKS + 1);
	localparam int TryW = $clog2(MAX_TRIES + 1);

	// Configuration registers.
	logic [6:0]  dead_zone_q;
	logic [11:0] limit_x_q;
	logic [11:0] limit_y_q;
	logic [7:0]  expected_id_q;

	logic                 cfg_wr;
	logic [CFG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q   <= DEAD_ZONE_RESET;
			limit_x_q     <= LIMIT_X_RESET;
			limit_y_q     <= LIMIT_Y_RESET;
			expected_id_q <= EXPECTED_ID_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_IDX_DEAD_ZONE:   dead_zone_q   <= pwdata[6:0];
				REG_IDX_LIMIT_X:     limit_x_q     <= pwdata[11:0];
				REG_IDX_LIMIT_Y:     limit_y_q     <= pwdata[11:0];
				REG_IDX_EXPECTED_ID: expected_id_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_IDX_DEAD_ZONE:   prdata = CFG_DATA_W'(dead_zone_q);
			REG_IDX_LIMIT_X:     prdata = CFG_DATA_W'(limit_x_q);
			REG_IDX_LIMIT_Y:     prdata = CFG_DATA_W'(limit_y_q);
			REG_IDX_EXPECTED_ID: prdata = CFG_DATA_W'(expected_id_q);
			default:             prdata = '0;
		endcase
	end

	// Sequencer state.
	step_t             step_q, step_d;
	phase_t            phase_q, phase_d;
	logic [4:0]        count_q, count_d, count_inc;
	logic [15:0]       shift_q, shift_d;
	logic [TryW-1:0]   tries_q, tries_d;
	logic [GapW-1:0]   gap_q, gap_d;
	logic [7:0]        held_dx_q, held_dx_d;
	logic [11:0]       pos_x_q, pos_x_d, pos_y_q, pos_y_d;
	logic [1:0]        flags_q, flags_d;

	logic              tick_acc;
	logic              poll_start;
	xfer_t             cur_xfer, start_xfer;
	logic              fin;
	logic [7:0]        fin_byte;
	logic              busy;
	logic signed [6:0] dx_step, dy_step;
	logic signed [13:0] new_x, new_y;
	result_t           res;

	assign cur_xfer   = step_xfer(step_q);
	assign poll_start = (cur_xfer.kind == KIND_NONE) && (step_q == STEP_READY) &&
	                    tick.poll_request;
	assign start_xfer = poll_start ? step_xfer(STEP_STATUS) : cur_xfer;
	assign count_inc  = count_q + 5'd1;

	assign busy = (phase_q != PH_IDLE) ||
	              (step_q inside {[STEP_ID:STEP_SETUP_LAST], [STEP_STATUS:STEP_DY]});

	// The last received byte is the dy byte when the y update uses it.
	assign dx_step = motion_delta(held_dx_q, dead_zone_q);
	assign dy_step = motion_delta(fin_byte, dead_zone_q);
	assign new_x   = $signed({2'b00, pos_x_q}) - 14'(dx_step);
	assign new_y   = $signed({2'b00, pos_y_q}) + 14'(dy_step);

	always_comb begin : next_state
		step_d    = step_q;
		phase_d   = phase_q;
		count_d   = count_q;
		shift_d   = shift_q;
		tries_d   = tries_q;
		gap_d     = gap_q;
		held_dx_d = held_dx_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		flags_d   = flags_q;
		fin       = 1'b0;
		fin_byte  = '0;

		case (phase_q)
			PH_IDLE: begin
				if (poll_start)
					step_d = STEP_STATUS;
				if (start_xfer.kind != KIND_NONE) begin
					shift_d = start_xfer.word;
					gap_d   = GapW'(GAP_TICKS);
					count_d = '0;
					phase_d = PH_GAP;
				end
			end
			PH_GAP: begin
				if (gap_q <= GapW'(1)) begin
					gap_d   = '0;
					count_d = '0;
					phase_d = PH_TX_LOW;
				end else begin
					gap_d = gap_q - GapW'(1);
				end
			end
			PH_TX_LOW: phase_d = PH_TX_HIGH;
			PH_TX_HIGH: begin
				shift_d = {shift_q[14:0], 1'b0};
				count_d = count_inc;
				if (cur_xfer.kind == KIND_READ && count_inc >= 5'(BITS_ADDR))
					phase_d = PH_TURN;
				else if (cur_xfer.kind != KIND_READ && count_inc >= 5'(BITS_WORD))
					fin = 1'b1;
				else
					phase_d = PH_TX_LOW;
			end
			PH_TURN: begin
				count_d = '0;
				shift_d = '0;
				phase_d = PH_RX_LOW;
			end
			PH_RX_LOW: phase_d = PH_RX_HIGH;
			PH_RX_HIGH: begin
				shift_d = {shift_q[14:0], tick.sda_sample};
				count_d = count_inc;
				if (count_inc >= 5'(BITS_ADDR)) begin
					fin      = 1'b1;
					fin_byte = shift_d[7:0];
				end else begin
					phase_d = PH_RX_LOW;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		// End of a transfer: advance the start-up or poll sequence.
		if (fin) begin
			phase_d = PH_IDLE;
			if (step_q == STEP_ID) begin
				if (fin_byte == expected_id_q) begin
					step_d = STEP_REG1;
				end else begin
					tries_d = tries_q + TryW'(1);
					if (tries_d >= TryW'(MAX_TRIES)) begin
						step_d  = STEP_FAILED;
						flags_d = FLAG_FAILED;
					end
				end
			end else if (step_q inside {[STEP_REG1:STEP_SETUP_LAST - 4'd1]}) begin
				step_d = step_q + 4'd1;
			end else if (step_q == STEP_SETUP_LAST) begin
				step_d  = STEP_READY;
				flags_d = FLAG_READY;
			end else if (step_q == STEP_STATUS) begin
				step_d = fin_byte[STATUS_MOTION_BIT] ? STEP_DX : STEP_READY;
			end else if (step_q == STEP_DX) begin
				held_dx_d = fin_byte;
				step_d    = STEP_DY;
			end else if (step_q == STEP_DY) begin
				pos_x_d = clamp_pos(new_x, limit_x_q);
				pos_y_d = clamp_pos(new_y, limit_y_q);
				step_d  = STEP_READY;
			end
		end
	end

	// Pin levels and status come from the state held at the start of the tick.
	always_comb begin : outputs
		res.clock_pin   = 1'b1;
		res.data_pin    = 1'b1;
		res.data_drive  = 1'b1;
		res.cursor_x    = pos_x_q;
		res.cursor_y    = pos_y_q;
		res.ready_res   = flags_q[0];
		res.init_failed = flags_q[1];
		res.busy_res    = busy;
		case (phase_q)
			PH_TX_LOW: begin
				res.clock_pin = 1'b0;
				res.data_pin  = shift_q[15];
			end
			PH_TX_HIGH: res.data_pin = shift_q[15];
			PH_TURN, PH_RX_HIGH: begin
				res.data_pin   = 1'b0;
				res.data_drive = 1'b0;
			end
			PH_RX_LOW: begin
				res.clock_pin  = 1'b0;
				res.data_pin   = 1'b0;
				res.data_drive = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_ID;
			phase_q   <= PH_IDLE;
			count_q   <= '0;
			shift_q   <= '0;
			tries_q   <= '0;
			gap_q     <= '0;
			held_dx_q <= '0;
			pos_x_q   <= POS_X_RESET;
			pos_y_q   <= POS_Y_RESET;
			flags_q   <= '0;
		end else if (tick_acc) begin
			step_q    <= step_d;
			phase_q   <= phase_d;
			count_q   <= count_d;
			shift_q   <= shift_d;
			tries_q   <= tries_d;
			gap_q     <= gap_d;
			held_dx_q <= held_dx_d;
			pos_x_q   <= pos_x_d;
			pos_y_q   <= pos_y_d;
			flags_q   <= flags_d;
		end
	end

	// Two-word output buffer: the skid word catches a report when the output
	// word is stalled, so a tick is still taken in that cycle.
	logic    out_v_q, skid_v_q, out_take;
	result_t out_q, skid_q;

	assign tick.ready = !skid_v_q;
	assign tick_acc   = tick.valid && tick.ready;
	assign out_take   = out_v_q && report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= tick_acc;
			end
		end else if (tick_acc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_take) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (tick_acc)
				out_q <= res;
		end else if (tick_acc) begin
			skid_q <= res;
		end
	end

	assign report.valid       = out_v_q;
	assign report.clock_pin   = out_q.clock_pin;
	assign report.data_pin    = out_q.data_pin;
	assign report.data_drive  = out_q.data_drive;
	assign report.cursor_x    = out_q.cursor_x;
	assign report.cursor_y    = out_q.cursor_y;
	assign report.ready_res   = out_q.ready_res;
	assign report.init_failed = out_q.init_failed;
	assign report.busy_res    = out_q.busy_res;

	// Ready and failed are exclusive outcomes of start-up.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(flags_q[0] && flags_q[1]))
		else $error("ready and failed flags set together");

	// The skid word is only ever filled behind a stalled output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word valid without output word");

	// Turnaround and receive phases belong to read steps only.
	a_rx_is_read: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TURN || phase_q == PH_RX_LOW || phase_q == PH_RX_HIGH) |->
		(cur_xfer.kind == KIND_READ))
		else $error("receive phase during a non-read step");

	// The last gap tick leads straight into the first clock-low tick.
	a_gap_to_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && phase_q == PH_GAP && gap_q == GapW'(1)) |=> (phase_q == PH_TX_LOW))
		else $error("gap did not end in a clock-low tick");

	// A failed start-up halts the sequencer for good.
	a_failed_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_FAILED) |=> (step_q == STEP_FAILED && phase_q == PH_IDLE))
		else $error("sequencer left the failed state");

endmodule
